FILE: src/periodic_timer_table_top_assert.svh
// assertion macros shared by the checker of periodic_timer_table_top
// both expect clk and rst_n in the scope where they are used
`ifndef PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PTT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PTT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ptt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants shared by the periodic timer table modules.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int NF_W            = $clog2(MAX_RESULTS + 1);

    localparam int OP_W            = 2;
    localparam int TIME_W          = 32;
    localparam int SLOT_W          = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_DATA_W-1:0] TICK_STEP_RESET = 16'd10;
    localparam logic [CFG_DATA_W-1:0] MIN_DELAY_RESET = 16'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_ADD     = 2'd1,
        OP_CANCEL  = 2'd2,
        OP_COLLECT = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_STEP = 1'b0,
        CFG_MIN_DELAY = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        ST_OK      = 1'b0,
        ST_NO_SLOT = 1'b1
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;          // latch item, restart the slot scan
        logic advance;       // clock += tick step
        logic tick_step;     // one step of the deadline scan
        logic free_step;     // one step of the free slot search
        logic add_commit;    // arm the found slot and send its index, or send no-slot if none
        logic cancel_commit; // free the named slot and send ok
        logic push_ok;       // send a plain ok result
        logic coll_step;     // one step of the due slot scan
        logic coll_finish;   // send the held due slot or an empty result
    } ptt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tick_done;
        logic free_done;
        logic coll_done;
        logic out_free;
    } ptt_status_t;

endpackage

FILE: src/ptt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_req_if / ptt_rsp_if
// Valid/ready channels for timer commands and their results.
// ----------------------------------------------------------------------------
interface ptt_req_if;
    logic                        valid;
    logic                        ready;
    logic [ptt_pkg::OP_W-1:0]    op;
    logic [ptt_pkg::TIME_W-1:0]  delay_ms;
    logic                        cyclic;
    logic [ptt_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, output op, output delay_ms, output cyclic,
                    output slot, input ready);
    modport sink   (input valid, input op, input delay_ms, input cyclic,
                    input slot, output ready);
endinterface

interface ptt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [ptt_pkg::SLOT_W-1:0]  slot_index;
    logic                        fired;
    logic                        last;

    modport source (output valid, output status, output slot_index, output fired,
                    output last, input ready);
    modport sink   (input valid, input status, input slot_index, input fired,
                    input last, output ready);
endinterface

FILE: src/periodic_timer_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_table_top
// Table of software timer slots driven by tick, add, cancel and collect.
// ----------------------------------------------------------------------------
// req carries one command per transfer (op, delay_ms, cyclic, slot); rsp
// returns its results, the final one flagged by last. Tick, add and cancel
// give one result; collect gives one result per due slot in ascending
// order, or a single empty result when nothing is due.
// One command is in work at a time; req.ready rises again once its last
// result is in the output register, so a new command can be taken while
// that result still waits. A tick reads the deadline and period memories
// once per slot; tick, add and collect all step the one shared slot scan
// counter, while a cancel needs no scan. A stalled rsp holds its result;
// any further result of the same command waits, and the scan pauses with
// it. Reset clears the clock, the slot flags and the output register and
// loads the register defaults (tick step 10 ms, minimum delay 2 ms). The
// deadline and period memories need no clearing pass. cfg_we writes a
// register in the cycle it is high; the user must write only while the
// block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module periodic_timer_table_top #(
    parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    ptt_req_if.sink                         req,
    ptt_rsp_if.source                       rsp
);

    ptt_pkg::ptt_cmd_t    cmd;
    ptt_pkg::ptt_status_t status;
    logic                 req_ready;

    ptt_ctrl u_ptt_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (ptt_pkg::op_t'(req.op)),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ptt_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ptt_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_delay_ms    (req.delay_ms),
        .in_cyclic      (req.cyclic),
        .in_slot        (req.slot),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_status     (rsp.status),
        .out_slot_index (rsp.slot_index),
        .out_fired      (rsp.fired),
        .out_last       (rsp.last)
    );

    assign req.ready = req_ready;

endmodule

FILE: src/ptt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer for the timer table: takes one command, steps the datapath
// through its slot scan and hands results to the output register.
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  ptt_pkg::op_t         req_op,
    output logic                 req_ready,
    input  ptt_pkg::ptt_status_t status,
    output ptt_pkg::ptt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_FINISH,
        S_FREE,
        S_ADD,
        S_CANCEL,
        S_COLL,
        S_CEND
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    cmd.load = 1'b1;
                    unique case (req_op)
                        ptt_pkg::OP_TICK:
                        begin
                            cmd.advance = 1'b1;
                            state_next  = S_TICK;
                        end
                        ptt_pkg::OP_ADD:     state_next = S_FREE;
                        ptt_pkg::OP_CANCEL:  state_next = S_CANCEL;
                        ptt_pkg::OP_COLLECT: state_next = S_COLL;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_TICK:
            begin
                if (status.tick_done)
                    state_next = S_FINISH;
                else
                    cmd.tick_step = 1'b1;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.push_ok = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FREE:
            begin
                if (status.free_done)
                    state_next = S_ADD;
                else
                    cmd.free_step = 1'b1;
            end
            S_ADD:
            begin
                if (status.out_free)
                begin
                    cmd.add_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CANCEL:
            begin
                if (status.out_free)
                begin
                    cmd.cancel_commit = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_COLL:
            begin
                // a step may send the previously held slot, so wait for room
                if (status.coll_done)
                    state_next = S_CEND;
                else if (status.out_free)
                    cmd.coll_step = 1'b1;
            end
            S_CEND:
            begin
                if (status.out_free)
                begin
                    cmd.coll_finish = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign req_ready = ready_reg;

endmodule

FILE: src/ptt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_dp
// Timer table datapath: millisecond clock, slot flags, deadline and period
// memories, the shared slot scan counter and the result register.
// ----------------------------------------------------------------------------
module ptt_dp #(
    parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [ptt_pkg::TIME_W-1:0]      in_delay_ms,
    input  logic                            in_cyclic,
    input  logic [ptt_pkg::SLOT_W-1:0]      in_slot,
    input  ptt_pkg::ptt_cmd_t               cmd,
    output ptt_pkg::ptt_status_t            status,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_status,
    output logic [ptt_pkg::SLOT_W-1:0]      out_slot_index,
    output logic                            out_fired,
    output logic                            out_last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int WIDE_W = IDX_W + ptt_pkg::SLOT_W;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_SLOTS);
    localparam logic [ptt_pkg::NF_W-1:0] NF_MAX = ptt_pkg::NF_W'(ptt_pkg::MAX_RESULTS);

    // configuration
    logic [ptt_pkg::CFG_DATA_W-1:0] step_reg, step_next;
    logic [ptt_pkg::CFG_DATA_W-1:0] min_reg, min_next;

    // table state
    logic [ptt_pkg::TIME_W-1:0] clock_reg, clock_next;
    logic [NUM_SLOTS-1:0]       active_reg, active_next;
    logic [NUM_SLOTS-1:0]       due_reg, due_next;
    logic [NUM_SLOTS-1:0]       repeat_reg, repeat_next;
    logic [ptt_pkg::TIME_W-1:0] deadline_mem [NUM_SLOTS];
    logic [ptt_pkg::TIME_W-1:0] period_mem [NUM_SLOTS];
    logic [ptt_pkg::TIME_W-1:0] rd_deadline_reg;
    logic [ptt_pkg::TIME_W-1:0] rd_period_reg;

    // latched item
    logic [ptt_pkg::TIME_W-1:0] delay_reg, delay_next;
    logic                       cyclic_reg, cyclic_next;
    logic [ptt_pkg::SLOT_W-1:0] slot_reg, slot_next;

    // scan control
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       stg_vld_reg, stg_vld_next;
    logic [IDX_W-1:0]           stg_idx_reg, stg_idx_next;
    logic                       hit_reg, hit_next;
    logic [IDX_W-1:0]           hit_idx_reg, hit_idx_next;
    logic [ptt_pkg::NF_W-1:0]   nfound_reg, nfound_next;

    // result register
    logic                       out_vld_reg, out_vld_next;
    logic                       out_status_reg, out_status_next;
    logic [ptt_pkg::SLOT_W-1:0] out_idx_reg, out_idx_next;
    logic                       out_fired_reg, out_fired_next;
    logic                       out_last_reg, out_last_next;

    logic [IDX_W-1:0]           cnt_idx;
    logic                       scan_end;
    logic                       coll_done;
    logic                       out_free;
    logic [WIDE_W-1:0]          slot_wide;
    logic                       slot_ok;
    logic [ptt_pkg::TIME_W-1:0] min_wide;
    logic                       stg_hit;
    logic                       rd_en;
    logic                       dl_we;
    logic [IDX_W-1:0]           dl_addr;
    logic [ptt_pkg::TIME_W-1:0] dl_wdata;
    logic                       pd_we;
    logic                       push;
    logic                       push_status;
    logic [IDX_W-1:0]           push_idx;
    logic                       push_fired;
    logic                       push_last;
    logic [WIDE_W-1:0]          push_wide;

    assign cnt_idx   = cnt_reg[IDX_W-1:0];
    assign scan_end  = (cnt_reg == CNT_END);
    assign coll_done = scan_end || (nfound_reg == NF_MAX);
    assign out_free  = !out_vld_reg || out_ready;
    assign slot_wide = {{IDX_W{1'b0}}, slot_reg};
    assign slot_ok   = (slot_wide < WIDE_W'(NUM_SLOTS));
    assign min_wide  = {{(ptt_pkg::TIME_W - ptt_pkg::CFG_DATA_W){1'b0}}, min_reg};
    assign stg_hit   = stg_vld_reg && active_reg[stg_idx_reg] && (rd_deadline_reg <= clock_reg);
    assign rd_en     = cmd.tick_step && !scan_end;

    always_comb
    begin
        step_next    = step_reg;
        min_next     = min_reg;
        clock_next   = clock_reg;
        active_next  = active_reg;
        due_next     = due_reg;
        repeat_next  = repeat_reg;
        delay_next   = delay_reg;
        cyclic_next  = cyclic_reg;
        slot_next    = slot_reg;
        cnt_next     = cnt_reg;
        stg_vld_next = stg_vld_reg;
        stg_idx_next = stg_idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        nfound_next  = nfound_reg;
        dl_we        = 1'b0;
        dl_addr      = stg_idx_reg;
        dl_wdata     = clock_reg + rd_period_reg;
        pd_we        = 1'b0;
        push         = 1'b0;
        push_status  = ptt_pkg::ST_OK;
        push_idx     = '0;
        push_fired   = 1'b0;
        push_last    = 1'b1;

        if (cfg_we)
        begin
            unique case (ptt_pkg::cfg_idx_t'(cfg_index))
                ptt_pkg::CFG_TICK_STEP: step_next = cfg_wdata;
                ptt_pkg::CFG_MIN_DELAY: min_next  = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            delay_next   = (in_delay_ms < min_wide) ? min_wide : in_delay_ms;
            cyclic_next  = in_cyclic;
            slot_next    = in_slot;
            cnt_next     = '0;
            stg_vld_next = 1'b0;
            hit_next     = 1'b0;
            nfound_next  = '0;
        end

        if (cmd.advance)
            clock_next = clock_reg + {{(ptt_pkg::TIME_W - ptt_pkg::CFG_DATA_W){1'b0}}, step_reg};

        // deadline scan: read at cnt, compare in the next cycle
        if (cmd.tick_step)
        begin
            stg_vld_next = !scan_end;
            stg_idx_next = cnt_idx;
            if (!scan_end)
                cnt_next = cnt_reg + 1'b1;
        end

        if (stg_hit)
        begin
            due_next[stg_idx_reg] = 1'b1;
            if (repeat_reg[stg_idx_reg])
                dl_we = 1'b1;
        end

        if (cmd.free_step && !hit_reg && !scan_end)
        begin
            if (!active_reg[cnt_idx])
            begin
                hit_next     = 1'b1;
                hit_idx_next = cnt_idx;
            end
            else
                cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.add_commit)
        begin
            push = 1'b1;
            if (hit_reg)
            begin
                active_next[hit_idx_reg] = 1'b1;
                due_next[hit_idx_reg]    = 1'b0;
                repeat_next[hit_idx_reg] = cyclic_reg;
                dl_we    = 1'b1;
                dl_addr  = hit_idx_reg;
                dl_wdata = clock_reg + delay_reg;
                pd_we    = 1'b1;
                push_idx = hit_idx_reg;
            end
            else
                push_status = ptt_pkg::ST_NO_SLOT;
        end

        if (cmd.cancel_commit)
        begin
            push = 1'b1;
            if (slot_ok)
                active_next[slot_wide[IDX_W-1:0]] = 1'b0;
        end

        if (cmd.push_ok)
            push = 1'b1;

        // a found slot is held until the next one shows whether it is the last
        if (cmd.coll_step && !coll_done)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (active_reg[cnt_idx] && due_reg[cnt_idx])
            begin
                due_next[cnt_idx] = 1'b0;
                if (!repeat_reg[cnt_idx])
                    active_next[cnt_idx] = 1'b0;
                if (hit_reg)
                begin
                    push       = 1'b1;
                    push_idx   = hit_idx_reg;
                    push_fired = 1'b1;
                    push_last  = 1'b0;
                end
                hit_next     = 1'b1;
                hit_idx_next = cnt_idx;
                nfound_next  = nfound_reg + 1'b1;
            end
        end

        if (cmd.coll_finish)
        begin
            push = 1'b1;
            if (hit_reg)
            begin
                push_idx   = hit_idx_reg;
                push_fired = 1'b1;
            end
        end
    end

    assign push_wide = {{ptt_pkg::SLOT_W{1'b0}}, push_idx};

    always_comb
    begin
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_fired_next  = out_fired_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            out_vld_next    = 1'b1;
            out_status_next = push_status;
            out_idx_next    = push_wide[ptt_pkg::SLOT_W-1:0];
            out_fired_next  = push_fired;
            out_last_next   = push_last;
        end
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ptt_pkg::TICK_STEP_RESET;
            min_reg     <= ptt_pkg::MIN_DELAY_RESET;
            clock_reg   <= '0;
            active_reg  <= '0;
            due_reg     <= '0;
            repeat_reg  <= '0;
            cnt_reg     <= '0;
            stg_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            nfound_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            min_reg     <= min_next;
            clock_reg   <= clock_next;
            active_reg  <= active_next;
            due_reg     <= due_next;
            repeat_reg  <= repeat_next;
            cnt_reg     <= cnt_next;
            stg_vld_reg <= stg_vld_next;
            hit_reg     <= hit_next;
            nfound_reg  <= nfound_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg      <= delay_next;
        cyclic_reg     <= cyclic_next;
        slot_reg       <= slot_next;
        stg_idx_reg    <= stg_idx_next;
        hit_idx_reg    <= hit_idx_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_fired_reg  <= out_fired_next;
        out_last_reg   <= out_last_next;
    end

    // slot memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (dl_we)
            deadline_mem[dl_addr] <= dl_wdata;
        if (pd_we)
            period_mem[hit_idx_reg] <= delay_reg;
        if (rd_en)
        begin
            rd_deadline_reg <= deadline_mem[cnt_idx];
            rd_period_reg   <= period_mem[cnt_idx];
        end
    end

    assign status.tick_done = scan_end && !stg_vld_reg;
    assign status.free_done = hit_reg || scan_end;
    assign status.coll_done = coll_done;
    assign status.out_free  = out_free;

    assign out_valid      = out_vld_reg;
    assign out_status     = out_status_reg;
    assign out_slot_index = out_idx_reg;
    assign out_fired      = out_fired_reg;
    assign out_last       = out_last_reg;

endmodule

FILE: src/ptt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks on the timer table, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_timer_table_top_assert.svh"

module ptt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_status,
    input logic [ptt_pkg::SLOT_W-1:0]  rsp_slot_index,
    input logic                        rsp_fired,
    input logic                        rsp_last
);

    // one command at a time: ready drops after every request transfer
    `PTT_ASSERT_NEXT(a_one_cmd, req_valid && req_ready, !req_ready, "ready held after transfer")

    // only due slots from a collect may be followed by more results
    `PTT_ASSERT_NOW(a_plain_last, rsp_valid && !rsp_fired, rsp_last, "plain result not last")

    `PTT_ASSERT_NOW(a_no_slot, rsp_valid && rsp_status,
        !rsp_fired && rsp_last && rsp_slot_index == '0, "bad no-slot result")

    `PTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_slot_index) && $stable(rsp_last) && $stable(rsp_fired),
        "result changed while stalled")

endmodule

bind periodic_timer_table_top ptt_checker u_ptt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_slot_index (rsp.slot_index),
    .rsp_fired      (rsp.fired),
    .rsp_last       (rsp.last)
);
